// ===== sv/sdc_pkg.sv =====
// Package for the selector DMA channel: command codes, register indexes,
// command-bit masks and the per-channel record type. No dependencies.
package sdc_pkg;

    localparam logic [3:0] CMD_SELECT  = 4'd0;
    localparam logic [3:0] CMD_RDADDR  = 4'd1;
    localparam logic [3:0] CMD_WRADDR  = 4'd2;
    localparam logic [3:0] CMD_SENSE   = 4'd3;
    localparam logic [3:0] CMD_COMMAND = 4'd4;
    localparam logic [3:0] CMD_SETDEV  = 4'd5;
    localparam logic [3:0] CMD_XFER    = 4'd6;
    localparam logic [3:0] CMD_STOP    = 4'd7;
    localparam logic [3:0] CMD_ACTIVE  = 4'd8;

    localparam logic [1:0] REG_ADDR_MODE = 2'd0;
    localparam logic [1:0] REG_CHAN_CNT  = 2'd1;
    localparam logic [1:0] REG_MEM_SIZE  = 2'd2;

    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_18 = 2'd1;
    localparam logic [1:0] MODE_20 = 2'd2;

    localparam logic [7:0] C_EXA  = 8'h40;
    localparam logic [7:0] C_RD   = 8'h20;
    localparam logic [7:0] C_GO   = 8'h10;
    localparam logic [7:0] C_STOP = 8'h08;
    localparam logic [7:0] C_SSTA = 8'h04;
    localparam logic [7:0] C_EXM  = 8'h03;
    localparam logic [7:0] ST_BUSY = 8'h08;

    localparam int ADDR_W = 24;

    typedef struct packed {
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] ea;
        logic [6:0]        cb;
        logic [7:0]        dev;
        logic [1:0]        rp;
        logic [2:0]        wc;
    } t_chan;

endpackage

// ===== sv/sdc_if.sv =====
// Valid/ready channel interfaces for the selector DMA channel.
// Depends on nothing.
interface sdc_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [1:0]  channel;
    logic [7:0]  data_byte;
    logic [7:0]  device_number;
    logic [15:0] request_count;
    logic        device_present;
    logic [7:0]  device_status;
    modport source(output valid, cmd, channel, data_byte, device_number, request_count,
                   device_present, device_status, input ready);
    modport sink(input valid, cmd, channel, data_byte, device_number, request_count,
                 device_present, device_status, output ready);
endinterface

interface sdc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic        no_device;
    logic        byte_only;
    logic [19:0] xfer_address;
    logic [15:0] xfer_count;
    logic        is_active;
    logic [3:0]  irq_pending;
    modport source(output valid, read_byte, no_device, byte_only, xfer_address, xfer_count,
                   is_active, irq_pending, input ready);
    modport sink(input valid, read_byte, no_device, byte_only, xfer_address, xfer_count,
                 is_active, irq_pending, output ready);
endinterface

interface sdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [20:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/selector_dma_channel.sv =====
// Top level of the selector DMA channel: channel record memory, read-modify-write
// sequencer and output register. Depends on sdc_pkg and sdc_if.
//
// channel   dir  word
// i_req     in   cmd, channel, data_byte, device_number, request_count, device_*
// o_rsp     out  read_byte, no_device, byte_only, xfer_*, is_active, irq_pending
// i_cfg     in   index, data (address_mode, channel_count, mem_size)
//
// Each word: a read of the channel memory, then modify and write back. Reset and a
// channel_count change start a clearing pass over the memory; no word is accepted
// during it. Interrupt bits sit in flip-flops. A waiting result blocks the next word
// only while the output register is full.
module selector_dma_channel
    import sdc_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int ADDR_BITS    = 20
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sdc_in_if.sink   i_req,
    sdc_out_if.source o_rsp,
    sdc_cfg_if.sink  i_cfg
);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] MASK16 = ADDR_W'(16'hFFFF);
    localparam logic [4:0] NCH = 5'(NUM_CHANNELS);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    t_chan r_mem [NUM_CHANNELS];
    t_chan r_rd;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_mode;
    logic [2:0]  r_ccnt;
    logic [20:0] r_msize;
    logic [NUM_CHANNELS-1:0] r_irq, n_irq;
    logic [CW:0] r_clr;
    logic [4:0]  r_eff;

    logic [3:0]  r_cmd;
    logic [CW-1:0] r_ch;
    logic        r_en;
    logic [7:0]  r_dat, r_dev, r_dstat;
    logic [15:0] r_req;
    logic        r_pres;

    logic        r_ovalid;
    logic [7:0]  r_rbyte;
    logic        r_nodev, r_bonly, r_act;
    logic [19:0] r_xaddr;
    logic [15:0] r_xcnt;

    logic        in_fire, cfg_fire, cnt_chg;
    logic [2:0]  cfg_cnt;
    logic [4:0]  new_eff;

    assign cfg_cnt = i_cfg.data[2:0];
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign cnt_chg = cfg_fire && i_cfg.index == REG_CHAN_CNT && cfg_cnt != 3'd0
                     && cfg_cnt != r_ccnt;
    assign new_eff = ({2'b0, cfg_cnt} > NCH) ? NCH : {2'b0, cfg_cnt};
    assign i_cfg.ready = (r_state == ST_IDLE);
    // hold the input while a register write is offered
    assign i_req.ready = (r_state == ST_IDLE) && !i_cfg.valid && (!r_ovalid || o_rsp.ready);
    assign in_fire = i_req.valid && i_req.ready;

    // modify stage
    t_chan w;
    logic  we;
    logic [7:0]  o_rb;
    logic        o_nd, o_bo, o_ac;
    logic [ADDR_W-1:0] o_xa;
    logic [16:0] o_xc;
    logic        m20;
    logic [7:0]  d;
    logic [ADDR_W-1:0] bank, lim, addr, endv;
    logic [16:0] xfr, inc;
    logic [ADDR_W:0] sum, span;
    logic        exr;

    always_comb begin
        w = r_rd;
        we = 1'b0;
        o_rb = 8'd0; o_nd = 1'b0; o_bo = 1'b0; o_ac = 1'b0;
        o_xa = '0; o_xc = '0;
        n_irq = r_irq;
        m20 = (r_mode == MODE_20);
        exr = r_rd.cb[6] && m20;
        d = r_dat;
        bank = '0;
        addr = r_rd.sa; endv = r_rd.ea;
        xfr = {1'b0, r_req}; inc = '0;
        span = {1'b0, endv} - {1'b0, addr} + 1'b1;
        sum = '0;
        lim = m20 ? AMASK : MASK16;
        if (r_en) begin
            unique case (r_cmd)
                CMD_SELECT: o_bo = 1'b1;
                CMD_RDADDR: begin
                    we = 1'b1;
                    o_rb = 8'(r_rd.sa >> {r_rd.rp, 3'b0});
                    if (r_rd.rp == 2'd0) w.rp = exr ? 2'd2 : 2'd1;
                    else w.rp = r_rd.rp - 2'd1;
                end
                CMD_WRADDR: begin
                    if (!m20) begin
                        if (r_rd.wc < 3'd4) begin
                            we = 1'b1;
                            w.sa = ((r_rd.sa << 8) | (r_rd.ea >> 8)) & MASK16;
                            w.ea = ((r_rd.ea << 8) | ADDR_W'(r_dat)) & MASK16;
                            w.wc = r_rd.wc + 3'd1;
                        end
                    end else if (r_rd.wc < 3'd6) begin
                        we = 1'b1;
                        w.wc = r_rd.wc + 3'd1;
                        if (r_rd.wc != 3'd5) begin
                            w.sa = ((r_rd.sa << 8) | ADDR_W'(r_rd.ea[15:8])) & AMASK;
                            w.ea = (ADDR_W'({r_rd.ea[7:0], r_dat})) & AMASK;
                        end else begin
                            w.ea = ((r_rd.ea << 8) | ADDR_W'(r_dat)) & AMASK;
                        end
                    end
                end
                CMD_SENSE: begin
                    if (r_rd.cb[4]) o_rb = ST_BUSY;
                    else if (r_rd.cb[2]) o_rb = 8'd0;
                    else if (!r_pres) o_nd = 1'b1;
                    else o_rb = r_dstat & ~ST_BUSY;
                end
                CMD_COMMAND: begin
                    if (!m20) begin
                        d = r_dat & ~(C_EXA | C_SSTA);
                        if (r_mode == MODE_18) bank = ADDR_W'({d[1:0], 16'h0});
                    end
                    if (d[3]) begin
                        we = 1'b1;
                        w.cb = 7'(d & (C_EXA | C_SSTA));
                        n_irq[r_ch] = 1'b0;
                        w.rp = (w.cb[6] && m20) ? 2'd2 : 2'd1;
                        w.wc = 3'd0;
                    end else if (d[4]) begin
                        we = 1'b1;
                        w.cb = 7'(d & (C_EXA | C_SSTA | C_GO | C_RD));
                        if (r_rd.wc <= 3'd4) begin
                            w.sa = ((r_rd.sa & MASK16) | bank) & AMASK;
                            w.ea = ((r_rd.ea & MASK16) | bank) & AMASK;
                        end
                        w.sa[0] = 1'b0;
                        if (w.ea <= w.sa) w.ea = (w.ea | lim) & AMASK;
                    end
                end
                CMD_SETDEV: begin
                    we = 1'b1;
                    w.dev = r_dev;
                end
                CMD_XFER: begin
                    if (r_rd.cb[4]) begin
                        we = 1'b1;
                        if (endv >= addr && span < {{(ADDR_W-16){1'b0}}, xfr})
                            xfr = span[16:0];
                        if ({{(ADDR_W-20){1'b0}}, r_msize} <= {1'b0, addr} || xfr == 17'd0)
                            inc = '0;
                        else if ({1'b0, addr} + ADDR_W'(xfr) - 1'b1
                                 >= {{(ADDR_W-20){1'b0}}, r_msize})
                            inc = 17'(r_msize - 21'(addr));
                        else
                            inc = xfr;
                        sum = {1'b0, addr} + (ADDR_W+1)'(inc);
                        if (sum > {1'b0, endv}) begin
                            n_irq[r_ch] = 1'b1;
                            w.cb[4] = 1'b0; w.cb[5] = 1'b0;
                            w.sa = (sum[ADDR_W-1:0] - 1'b1) & AMASK;
                        end else begin
                            w.sa = sum[ADDR_W-1:0] & AMASK;
                        end
                        o_xa = addr;
                        o_xc = inc;
                    end
                end
                CMD_STOP: begin
                    we = 1'b1;
                    n_irq[r_ch] = 1'b1;
                    w.cb[4] = 1'b0; w.cb[5] = 1'b0;
                end
                CMD_ACTIVE: o_ac = r_rd.cb[4] && (r_rd.dev == r_dev);
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (r_clr == (CW+1)'(NUM_CHANNELS - 1)) n_state = ST_IDLE;
            ST_IDLE: if (cnt_chg) n_state = ST_CLR;
                     else if (in_fire) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // channel memory: clearing pass, read, write back
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            if ({1'b0, r_clr} >= {1'b0, r_eff[CW:0]})
                r_mem[r_clr[CW-1:0]] <= '{sa: '0, ea: '0, cb: '0, dev: '0, rp: 2'd1, wc: '0};
        end else if (r_state == ST_EXEC && we) begin
            r_mem[r_ch] <= w;
        end
        if (in_fire) r_rd <= r_mem[CW'(i_req.channel)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr <= '0;
            r_eff <= 5'd0;
            r_mode <= MODE_20;
            r_ccnt <= 3'd2;
            r_msize <= 21'h100000;
            r_irq <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                if ({1'b0, r_clr} >= {1'b0, r_eff[CW:0]})
                    r_irq[r_clr[CW-1:0]] <= 1'b0;
                r_clr <= r_clr + 1'b1;
            end else begin
                if (cnt_chg) begin
                    r_clr <= '0;
                    r_eff <= new_eff;
                end
                if (r_state == ST_EXEC) r_irq <= n_irq;
            end
            if (cfg_fire) begin
                unique case (i_cfg.index)
                    REG_ADDR_MODE: r_mode <= i_cfg.data[1:0];
                    REG_CHAN_CNT:  if (cfg_cnt != 3'd0) r_ccnt <= cfg_cnt;
                    REG_MEM_SIZE:  r_msize <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == ST_EXEC) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    logic [4:0] eff_now;
    assign eff_now = ({2'b0, r_ccnt} > NCH) ? NCH : {2'b0, r_ccnt};

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_req.cmd;
            r_ch <= CW'(i_req.channel);
            r_en <= {3'b0, i_req.channel} < eff_now;
            r_dat <= i_req.data_byte;
            r_dev <= i_req.device_number;
            r_req <= i_req.request_count;
            r_pres <= i_req.device_present;
            r_dstat <= i_req.device_status;
        end
        if (r_state == ST_EXEC) begin
            r_rbyte <= o_rb;
            r_nodev <= o_nd;
            r_bonly <= o_bo;
            r_act <= o_ac;
            r_xaddr <= o_xa[19:0];
            r_xcnt <= o_xc[15:0];
        end
    end

    logic [3:0] irq4;
    always_comb begin
        irq4 = '0;
        for (int k = 0; k < 4 && k < NUM_CHANNELS; k++) irq4[k] = r_irq[k];
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.read_byte = r_rbyte;
    assign o_rsp.no_device = r_nodev;
    assign o_rsp.byte_only = r_bonly;
    assign o_rsp.xfer_address = r_xaddr;
    assign o_rsp.xfer_count = r_xcnt;
    assign o_rsp.is_active = r_act;
    assign o_rsp.irq_pending = irq4;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLR |-> !i_req.ready) else $error("word accepted during clear");
    a_exec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXEC |=> r_ovalid && r_state != ST_EXEC) else $error("exec overlap");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_rsp.ready && r_state != ST_EXEC |=> r_ovalid)
        else $error("result dropped");
endmodule
